// ===== rtl/gptdn_pkg.sv =====
// ----------------------------------------------------------------------------
// gptdn_pkg
// Shared types, constants and tables for the geographic point table unit.
// ----------------------------------------------------------------------------
package gptdn_pkg;

  // Field widths
  localparam int LAT_W   = 31;
  localparam int LON_W   = 32;
  localparam int TOL_W   = 17;
  localparam int STAT_W  = 2;
  localparam int COORD_W = 32;

  localparam logic [TOL_W-1:0] TOL_RESET = 17'd1000;

  // Angle reduction: 1e-7 degree units, one turn is 360 degrees
  localparam int UNIT_W = 34;
  localparam int REM_W  = 32;
  localparam int ANG_W  = 32;
  localparam logic signed [UNIT_W-1:0] TURN_UNITS = 34'sd3600000000;
  localparam logic [ANG_W-1:0] QUARTER_TURN = 32'h4000_0000;

  // floor(2^64 / one turn): estimate of the binary angle, low by at most one
  localparam logic [32:0] TURN_RECIP = 33'(64'hFFFF_FFFF_FFFF_FFFF / 64'd3600000000);

  // Iteration counts of the shared divider and rotator
  localparam int STEP_W    = 5;
  localparam int DIV_STEPS = 3;
  localparam int ROT_STEPS = 24;

  // Divider steps: reciprocal multiply, remainder check, then correct
  localparam int DIV_MUL = 0;
  localparam int DIV_CHK = 1;

  // Q30 fixed point
  localparam int Q_SHIFT = 30;
  localparam int TRIG_W  = 32;
  localparam int PROD_W  = 64;
  localparam int HAV_W   = 33;
  localparam logic signed [UNIT_W-1:0] ROT_GAIN = 34'sd652032874;
  localparam logic signed [UNIT_W-1:0] Q30_ONE  = 34'sd1073741824;

  typedef enum logic [0:0] {
    CMD_FIND_ADD = 1'b0,
    CMD_NEAREST  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_MATCH = 2'd0,
    ST_ADDED = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // Which angle the shared trig unit works on
  typedef enum logic [1:0] {
    PH_QCOS = 2'd0,
    PH_DLAT = 2'd1,
    PH_DLON = 2'd2,
    PH_PCOS = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    MS_SQ = 2'd0,
    MS_CC = 2'd1,
    MS_AC = 2'd2
  } mul_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_RD,
    S_FA_CHK,
    S_ADD,
    S_ANG,
    S_WRAP,
    S_DIV,
    S_ROT0,
    S_ROT,
    S_TRIG,
    S_POST,
    S_MULW,
    S_MUL2,
    S_ACC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic     capture;
    logic     idx_clr;
    logic     idx_inc;
    logic     add;
    logic     res_load;
    status_t  res_status;
    logic     ang_load;
    phase_t   phase;
    logic     wrap;
    logic     div_step;
    logic     rot_load;
    logic     rot_step;
    logic [STEP_W-1:0] step;
    logic     trig_store;
    logic     c1_load;
    logic     mul;
    mul_sel_t msel;
    logic     slat_load;
    logic     slon_load;
    logic     cc_load;
    logic     acc;
  } dp_cmd_t;

  typedef struct packed {
    logic cmd_near;
    logic empty;
    logic full;
    logic last;
    logic match;
    logic wrap_done;
  } dp_sts_t;

  // Rotation angles atan(2^-k), one turn = 2^32
  function automatic logic [29:0] atan_step(input logic [STEP_W-1:0] k);
    logic [29:0] v;
    case (k)
      5'd0:    v = 30'h20000000;
      5'd1:    v = 30'h12E4051E;
      5'd2:    v = 30'h09FB385B;
      5'd3:    v = 30'h051111D4;
      5'd4:    v = 30'h028B0D43;
      5'd5:    v = 30'h0145D7E1;
      5'd6:    v = 30'h00A2F61E;
      5'd7:    v = 30'h00517C55;
      5'd8:    v = 30'h0028BE53;
      5'd9:    v = 30'h00145F2F;
      5'd10:   v = 30'h000A2F98;
      5'd11:   v = 30'h000517CC;
      5'd12:   v = 30'h00028BE6;
      5'd13:   v = 30'h000145F3;
      5'd14:   v = 30'h0000A2FA;
      5'd15:   v = 30'h0000517D;
      5'd16:   v = 30'h000028BE;
      5'd17:   v = 30'h0000145F;
      5'd18:   v = 30'h00000A30;
      5'd19:   v = 30'h00000518;
      5'd20:   v = 30'h0000028C;
      5'd21:   v = 30'h00000146;
      5'd22:   v = 30'h000000A3;
      5'd23:   v = 30'h00000051;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/gptdn_ram.sv =====
// ----------------------------------------------------------------------------
// gptdn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gptdn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/gptdn_dp.sv =====
// ----------------------------------------------------------------------------
// gptdn_dp
// Datapath: point storage, scan index, tolerance match, angle reduction,
// reciprocal divider, shared CORDIC rotator, multiplier and best tracking.
// ----------------------------------------------------------------------------
module gptdn_dp #(
  parameter int TABLE_DEPTH = 1024,
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gptdn_pkg::TOL_W-1:0]   cfg_wdata,
  input  logic [63:0]                   in_tdata,
  input  logic [0:0]                    in_tuser,
  input  gptdn_pkg::dp_cmd_t            cmd,
  output gptdn_pkg::dp_sts_t            sts,
  output logic [IDX_W-1:0]              res_idx,
  output gptdn_pkg::status_t            res_status,
  output logic [CNT_W-1:0]              count
);

  localparam int UW = gptdn_pkg::UNIT_W;
  localparam int RW = gptdn_pkg::REM_W;
  localparam int TW = gptdn_pkg::TRIG_W;
  localparam int HW = gptdn_pkg::HAV_W;

  logic [gptdn_pkg::TOL_W-1:0]          tol_r;
  gptdn_pkg::cmd_t                      q_cmd_r;
  logic signed [gptdn_pkg::LAT_W-1:0]   q_lat_r;
  logic signed [gptdn_pkg::LON_W-1:0]   q_lon_r;
  logic [CNT_W-1:0]                     count_r;
  logic [IDX_W-1:0]                     idx_r;
  logic [IDX_W-1:0]                     res_idx_r;
  gptdn_pkg::status_t                   res_status_r;
  logic signed [gptdn_pkg::COORD_W-1:0] rd_lat;
  logic signed [gptdn_pkg::COORD_W-1:0] rd_lon;
  logic signed [gptdn_pkg::COORD_W-1:0] q_lat_ext;
  logic                                 we;

  logic signed [UW-1:0]                 unit_r;
  logic [RW-1:0]                        rem_r;
  logic [gptdn_pkg::ANG_W-1:0]          quo_r;
  logic [UW-1:0]                        dchk_r;
  logic signed [UW-1:0]                 x_r, y_r, z_r;
  logic                                 flip_r;
  logic signed [TW-1:0]                 cs_r, sn_r, c1_r, slat2_r, slon2_r, cc_r;
  logic signed [gptdn_pkg::PROD_W-1:0]  prod_r;
  logic signed [HW-1:0]                 best_r;
  logic [IDX_W-1:0]                     best_idx_r;

  logic signed [32:0]                   dl, dn;
  logic [32:0]                          dl_abs, dn_abs;
  logic [UW-1:0]                        qd_lo;
  logic [gptdn_pkg::ANG_W-1:0]          ang, fold_d, ang2;
  logic                                 fold;
  logic signed [UW-1:0]                 dx, dy, at;
  logic signed [UW-1:0]                 xf, yf, xc, yc;
  logic signed [TW-1:0]                 mul_a, mul_b, prod_sh;
  logic signed [HW-1:0]                 hav;
  logic                                 take_best;

  assign q_lat_ext = gptdn_pkg::COORD_W'(q_lat_r);

  // Point storage
  gptdn_ram #(.WIDTH(gptdn_pkg::COORD_W), .DEPTH(TABLE_DEPTH)) u_lat_ram (
    .clk(clk), .we(we), .waddr(count_r[IDX_W-1:0]), .wdata(q_lat_ext),
    .raddr(idx_r), .rdata(rd_lat)
  );

  gptdn_ram #(.WIDTH(gptdn_pkg::COORD_W), .DEPTH(TABLE_DEPTH)) u_lon_ram (
    .clk(clk), .we(we), .waddr(count_r[IDX_W-1:0]), .wdata(q_lon_r),
    .raddr(idx_r), .rdata(rd_lon)
  );

  assign we = cmd.add && !sts.full;

  // Status toward the controller
  always_comb begin
    dl     = 33'(rd_lat) - 33'(q_lat_ext);
    dn     = 33'(rd_lon) - 33'(q_lon_r);
    dl_abs = dl[32] ? 33'(-dl) : 33'(dl);
    dn_abs = dn[32] ? 33'(-dn) : 33'(dn);
    sts.cmd_near  = (q_cmd_r == gptdn_pkg::CMD_NEAREST);
    sts.empty     = (count_r == '0);
    sts.full      = (count_r == CNT_W'(TABLE_DEPTH));
    sts.last      = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
    sts.match     = (dl_abs < 33'(tol_r)) && (dn_abs < 33'(tol_r));
    sts.wrap_done = !unit_r[UW-1] && (unit_r < gptdn_pkg::TURN_UNITS);
  end

  // Control registers: tolerance, count, scan index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r   <= gptdn_pkg::TOL_RESET;
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      if (cfg_we) begin
        tol_r <= cfg_wdata;
      end
      if (we) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  // Capture query and result fields
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q_cmd_r <= gptdn_pkg::cmd_t'(in_tuser[0]);
      q_lat_r <= in_tdata[30:0];
      q_lon_r <= in_tdata[62:31];
    end
    if (cmd.res_load) begin
      res_status_r <= cmd.res_status;
      case (cmd.res_status)
        gptdn_pkg::ST_MATCH: begin
          res_idx_r <= (sts.cmd_near && !take_best) ? best_idx_r : idx_r;
        end
        gptdn_pkg::ST_ADDED: res_idx_r <= count_r[IDX_W-1:0];
        default:             res_idx_r <= '0;
      endcase
    end
  end

  // Angle reduction and divide by one turn: the reciprocal estimate is low
  // by at most one, so one remainder check settles the quotient
  always_comb begin
    qd_lo = UW'(quo_r) * UW'(gptdn_pkg::TURN_UNITS);
  end

  always_ff @(posedge clk) begin
    if (cmd.ang_load) begin
      case (cmd.phase)
        gptdn_pkg::PH_QCOS: unit_r <= UW'(q_lat_ext);
        gptdn_pkg::PH_DLAT: unit_r <= UW'(rd_lat) - UW'(q_lat_ext);
        gptdn_pkg::PH_DLON: unit_r <= UW'(rd_lon) - UW'(q_lon_r);
        default:            unit_r <= UW'(rd_lat);
      endcase
    end else if (cmd.wrap) begin
      if (unit_r[UW-1]) begin
        unit_r <= unit_r + gptdn_pkg::TURN_UNITS;
      end else if (unit_r >= gptdn_pkg::TURN_UNITS) begin
        unit_r <= unit_r - gptdn_pkg::TURN_UNITS;
      end else begin
        rem_r <= unit_r[RW-1:0];
        quo_r <= '0;
      end
    end else if (cmd.div_step) begin
      if (cmd.step == gptdn_pkg::STEP_W'(gptdn_pkg::DIV_MUL)) begin
        quo_r <= gptdn_pkg::ANG_W'((64'(rem_r) * 64'(gptdn_pkg::TURN_RECIP)) >> 32);
      end else if (cmd.step == gptdn_pkg::STEP_W'(gptdn_pkg::DIV_CHK)) begin
        dchk_r <= {rem_r[1:0], 32'b0} - qd_lo;
      end else if (dchk_r >= UW'(gptdn_pkg::TURN_UNITS)) begin
        quo_r <= quo_r + gptdn_pkg::ANG_W'(1);
      end
    end
  end

  // CORDIC rotator: fold into [-90,90) degrees, then one step per cycle
  always_comb begin
    ang = ((cmd.phase == gptdn_pkg::PH_DLAT) || (cmd.phase == gptdn_pkg::PH_DLON))
          ? {1'b0, quo_r[gptdn_pkg::ANG_W-1:1]} : quo_r;
    fold_d = ang - gptdn_pkg::QUARTER_TURN;
    fold   = !fold_d[gptdn_pkg::ANG_W-1];
    ang2   = ang ^ {fold, {(gptdn_pkg::ANG_W-1){1'b0}}};
    dx = y_r >>> cmd.step;
    dy = x_r >>> cmd.step;
    at = UW'({1'b0, gptdn_pkg::atan_step(cmd.step)});
    xf = flip_r ? -x_r : x_r;
    yf = flip_r ? -y_r : y_r;
    xc = (xf > gptdn_pkg::Q30_ONE) ? gptdn_pkg::Q30_ONE :
         (xf < -gptdn_pkg::Q30_ONE) ? -gptdn_pkg::Q30_ONE : xf;
    yc = (yf > gptdn_pkg::Q30_ONE) ? gptdn_pkg::Q30_ONE :
         (yf < -gptdn_pkg::Q30_ONE) ? -gptdn_pkg::Q30_ONE : yf;
  end

  always_ff @(posedge clk) begin
    if (cmd.rot_load) begin
      x_r    <= gptdn_pkg::ROT_GAIN;
      y_r    <= '0;
      z_r    <= UW'($signed(ang2));
      flip_r <= fold;
    end else if (cmd.rot_step) begin
      if (!z_r[UW-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
    end
    if (cmd.trig_store) begin
      cs_r <= TW'(xc);
      sn_r <= TW'(yc);
    end
  end

  // Shared multiplier and haversine term assembly
  always_comb begin
    case (cmd.msel)
      gptdn_pkg::MS_SQ: begin mul_a = sn_r; mul_b = sn_r;    end
      gptdn_pkg::MS_CC: begin mul_a = c1_r; mul_b = cs_r;    end
      gptdn_pkg::MS_AC: begin mul_a = cc_r; mul_b = slon2_r; end
      default:          begin mul_a = '0;   mul_b = '0;      end
    endcase
    prod_sh   = TW'(prod_r >>> gptdn_pkg::Q_SHIFT);
    hav       = HW'(slat2_r) + HW'(prod_sh);
    take_best = cmd.acc && ((idx_r == '0) || (hav < best_r));
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.c1_load) begin
      c1_r <= cs_r;
    end
    if (cmd.slat_load) begin
      slat2_r <= prod_sh;
    end
    if (cmd.slon_load) begin
      slon2_r <= prod_sh;
    end
    if (cmd.cc_load) begin
      cc_r <= prod_sh;
    end
    // Keep the first point with the least term
    if (take_best) begin
      best_r     <= hav;
      best_idx_r <= idx_r;
    end
  end

  assign res_idx    = res_idx_r;
  assign res_status = res_status_r;
  assign count      = count_r;

endmodule

// ===== rtl/gptdn_ctrl.sv =====
// ----------------------------------------------------------------------------
// gptdn_ctrl
// Controller: sequences the table scan, the trig unit and the result hand-off.
// ----------------------------------------------------------------------------
module gptdn_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               out_free,
  output logic               out_load,
  output gptdn_pkg::dp_cmd_t cmd,
  input  gptdn_pkg::dp_sts_t sts
);

  localparam logic [gptdn_pkg::STEP_W-1:0] DIV_LAST =
    gptdn_pkg::STEP_W'(gptdn_pkg::DIV_STEPS - 1);
  localparam logic [gptdn_pkg::STEP_W-1:0] ROT_LAST =
    gptdn_pkg::STEP_W'(gptdn_pkg::ROT_STEPS - 1);

  gptdn_pkg::state_t state_r, state_nxt;
  gptdn_pkg::phase_t phase_r, phase_nxt;
  logic [gptdn_pkg::STEP_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gptdn_pkg::S_IDLE;
      phase_r <= gptdn_pkg::PH_QCOS;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      gptdn_pkg::S_IDLE: begin
        if (in_valid) state_nxt = gptdn_pkg::S_START;
      end
      gptdn_pkg::S_START: begin
        if (!sts.cmd_near) begin
          state_nxt = sts.empty ? gptdn_pkg::S_ADD : gptdn_pkg::S_RD;
        end else if (sts.empty) begin
          state_nxt = gptdn_pkg::S_DONE;
        end else begin
          phase_nxt = gptdn_pkg::PH_QCOS;
          state_nxt = gptdn_pkg::S_ANG;
        end
      end
      gptdn_pkg::S_RD: begin
        state_nxt = sts.cmd_near ? gptdn_pkg::S_ANG : gptdn_pkg::S_FA_CHK;
      end
      gptdn_pkg::S_FA_CHK: begin
        if (sts.match) state_nxt = gptdn_pkg::S_DONE;
        else if (sts.last) state_nxt = gptdn_pkg::S_ADD;
        else state_nxt = gptdn_pkg::S_RD;
      end
      gptdn_pkg::S_ADD: state_nxt = gptdn_pkg::S_DONE;
      gptdn_pkg::S_ANG: state_nxt = gptdn_pkg::S_WRAP;
      gptdn_pkg::S_WRAP: begin
        if (sts.wrap_done) begin
          cnt_nxt   = '0;
          state_nxt = gptdn_pkg::S_DIV;
        end
      end
      gptdn_pkg::S_DIV: begin
        cnt_nxt = cnt_r + gptdn_pkg::STEP_W'(1);
        if (cnt_r == DIV_LAST) state_nxt = gptdn_pkg::S_ROT0;
      end
      gptdn_pkg::S_ROT0: begin
        cnt_nxt   = '0;
        state_nxt = gptdn_pkg::S_ROT;
      end
      gptdn_pkg::S_ROT: begin
        cnt_nxt = cnt_r + gptdn_pkg::STEP_W'(1);
        if (cnt_r == ROT_LAST) state_nxt = gptdn_pkg::S_TRIG;
      end
      gptdn_pkg::S_TRIG: state_nxt = gptdn_pkg::S_POST;
      gptdn_pkg::S_POST: begin
        if (phase_r == gptdn_pkg::PH_QCOS) begin
          phase_nxt = gptdn_pkg::PH_DLAT;
          state_nxt = gptdn_pkg::S_RD;
        end else begin
          state_nxt = gptdn_pkg::S_MULW;
        end
      end
      gptdn_pkg::S_MULW: begin
        case (phase_r)
          gptdn_pkg::PH_DLAT: begin
            phase_nxt = gptdn_pkg::PH_DLON;
            state_nxt = gptdn_pkg::S_ANG;
          end
          gptdn_pkg::PH_DLON: begin
            phase_nxt = gptdn_pkg::PH_PCOS;
            state_nxt = gptdn_pkg::S_ANG;
          end
          default: state_nxt = gptdn_pkg::S_MUL2;
        endcase
      end
      gptdn_pkg::S_MUL2: state_nxt = gptdn_pkg::S_ACC;
      gptdn_pkg::S_ACC: begin
        if (sts.last) begin
          state_nxt = gptdn_pkg::S_DONE;
        end else begin
          phase_nxt = gptdn_pkg::PH_DLAT;
          state_nxt = gptdn_pkg::S_RD;
        end
      end
      gptdn_pkg::S_DONE: begin
        if (out_free) state_nxt = gptdn_pkg::S_IDLE;
      end
      default: state_nxt = gptdn_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd        = '0;
    cmd.phase  = phase_r;
    cmd.step   = cnt_r;
    cmd.msel   = (phase_r == gptdn_pkg::PH_PCOS) ? gptdn_pkg::MS_CC : gptdn_pkg::MS_SQ;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      gptdn_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        cmd.idx_clr = in_valid;
      end
      gptdn_pkg::S_START: begin
        if (sts.cmd_near && sts.empty) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = gptdn_pkg::ST_EMPTY;
        end
      end
      gptdn_pkg::S_FA_CHK: begin
        if (sts.match) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = gptdn_pkg::ST_MATCH;
        end else if (!sts.last) begin
          cmd.idx_inc = 1'b1;
        end
      end
      gptdn_pkg::S_ADD: begin
        cmd.add        = 1'b1;
        cmd.res_load   = 1'b1;
        cmd.res_status = sts.full ? gptdn_pkg::ST_FULL : gptdn_pkg::ST_ADDED;
      end
      gptdn_pkg::S_ANG:  cmd.ang_load   = 1'b1;
      gptdn_pkg::S_WRAP: cmd.wrap       = 1'b1;
      gptdn_pkg::S_DIV:  cmd.div_step   = 1'b1;
      gptdn_pkg::S_ROT0: cmd.rot_load   = 1'b1;
      gptdn_pkg::S_ROT:  cmd.rot_step   = 1'b1;
      gptdn_pkg::S_TRIG: cmd.trig_store = 1'b1;
      gptdn_pkg::S_POST: begin
        if (phase_r == gptdn_pkg::PH_QCOS) cmd.c1_load = 1'b1;
        else cmd.mul = 1'b1;
      end
      gptdn_pkg::S_MULW: begin
        cmd.slat_load = (phase_r == gptdn_pkg::PH_DLAT);
        cmd.slon_load = (phase_r == gptdn_pkg::PH_DLON);
        cmd.cc_load   = (phase_r == gptdn_pkg::PH_PCOS);
      end
      gptdn_pkg::S_MUL2: begin
        cmd.mul  = 1'b1;
        cmd.msel = gptdn_pkg::MS_AC;
      end
      gptdn_pkg::S_ACC: cmd.acc = 1'b1;
      gptdn_pkg::S_DONE: begin
        out_load = out_free;
      end
      default: ;
    endcase
    // Nearest result is ready once the last point is folded in
    if (state_r == gptdn_pkg::S_ACC && sts.last) begin
      cmd.res_load   = 1'b1;
      cmd.res_status = gptdn_pkg::ST_MATCH;
    end else if (state_r == gptdn_pkg::S_ACC) begin
      cmd.idx_inc = 1'b1;
    end
  end

endmodule

// ===== rtl/geo_point_table_dedup_nearest_unit.sv =====
// Find-or-add scans the stored entries until one matches; nearest works out the query
// cosine once, then each stored point in turn, through the 3-step reciprocal divide and
// 24-step CORDIC shared for three angles per point.
// One item is worked on at a time; the next is taken while a result waits.
// Reset (rst_n low, synchronous) empties the table and sets the tolerance to
// 1000; no clearing pass is needed since only written entries are read.
// ----------------------------------------------------------------------------
// geo_point_table_dedup_nearest_unit
// Point table with find-or-add by tolerance and nearest point by haversine.
// ----------------------------------------------------------------------------
module geo_point_table_dedup_nearest_unit #(
  parameter int TABLE_DEPTH = 1024,
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1),
  localparam int RES_W = IDX_W + gptdn_pkg::STAT_W + CNT_W,
  localparam int OUT_W = ((RES_W + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [gptdn_pkg::TOL_W-1:0] cfg_data,   // match_tolerance
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [63:0]                 in_tdata,   // latitude, longitude, zero pad
  input  logic [0:0]                  in_tuser,   // command
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [OUT_W-1:0]            out_tdata   // point_index, status, point_count, pad
);

  gptdn_pkg::dp_cmd_t cmd;
  gptdn_pkg::dp_sts_t sts;
  logic [IDX_W-1:0]   res_idx;
  gptdn_pkg::status_t res_status;
  logic [CNT_W-1:0]   count;
  logic               out_free, out_load;
  logic               out_tvalid_r;
  logic [OUT_W-1:0]   out_tdata_r;

  assign cfg_ready = 1'b1;

  gptdn_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .out_free(out_free), .out_load(out_load), .cmd(cmd), .sts(sts)
  );

  gptdn_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_valid), .cfg_wdata(cfg_data),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .cmd(cmd), .sts(sts),
    .res_idx(res_idx), .res_status(res_status), .count(count)
  );

  // Output register: hold the item until taken
  assign out_free = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= OUT_W'({count, res_status, res_idx});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== rtl/gptdn_chk.sv =====
// ----------------------------------------------------------------------------
// gptdn_chk
// Port-level checks on the result stream of the point table unit.
// ----------------------------------------------------------------------------
module gptdn_chk #(
  parameter int TABLE_DEPTH = 1024,
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1),
  localparam int RES_W = IDX_W + gptdn_pkg::STAT_W + CNT_W,
  localparam int OUT_W = ((RES_W + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  logic [IDX_W-1:0]            idx;
  logic [gptdn_pkg::STAT_W-1:0] st;
  logic [CNT_W-1:0]            cnt;

  assign idx = out_tdata[IDX_W-1:0];
  assign st  = out_tdata[IDX_W +: gptdn_pkg::STAT_W];
  assign cnt = out_tdata[IDX_W + gptdn_pkg::STAT_W +: CNT_W];

  // Hold a stalled item
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // No index when nothing was found or stored
  a_none_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (st == gptdn_pkg::ST_FULL || st == gptdn_pkg::ST_EMPTY) |-> idx == '0)
    else $error("index not zero for full or empty status");

  // A new point is the last one stored
  a_added: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st == gptdn_pkg::ST_ADDED |-> (CNT_W'(idx) + CNT_W'(1)) == cnt)
    else $error("added index does not match count");

  // Full only when the count reached the depth
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st == gptdn_pkg::ST_FULL |-> cnt == CNT_W'(TABLE_DEPTH))
    else $error("table full reported below depth");

endmodule

bind geo_point_table_dedup_nearest_unit gptdn_chk #(.TABLE_DEPTH(TABLE_DEPTH)) u_chk (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata)
);

// ===== verif/geo_point_table_dedup_nearest_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// geo_point_table_dedup_nearest_unit_test
// Self-checking bench for the point table: find-or-add by tolerance and
// nearest point by fixed-point haversine, predicted in a scoreboard and
// checked item by item under random idling, back-pressure and table fill.
// ----------------------------------------------------------------------------
module geo_point_table_dedup_nearest_unit_test;
  import gptdn_pkg::*;

  localparam int DEPTH      = 1024;
  localparam int OUT_BITS   = 24;
  localparam int STALL_MAX  = 1000000;
  localparam int SMALL_CAP  = 12;
  localparam int GROW_CAP   = 20;
  localparam longint TURN   = 64'sd3600000000;
  localparam longint Q_ONE  = 64'sd1073741824;
  localparam longint R_GAIN = 64'sd652032874;

  typedef struct {
    logic [9:0]  point_index;
    status_t     status;
    logic [10:0] point_count;
  } table_reply_t;

  // Scoreboard: mirror of the point table and the expected replies
  class point_table_scoreboard;
    int          lat_tab[DEPTH];
    int          lon_tab[DEPTH];
    int          count;
    int          tolerance;
    int          errors;
    table_reply_t replies[$];

    function new();
      count     = 0;
      tolerance = int'(TOL_RESET);
      errors    = 0;
    endfunction

    function longint half_or_full(longint units, int sh);
      longint r;
      longint unsigned num;
      r = units % TURN;
      if (r < 0) r += TURN;
      num = longint'(r) << sh;
      return longint'(num / 64'd3600000000);
    endfunction

    function void sin_cos(input logic [31:0] ang, output longint cs, output longint sn);
      logic [31:0] t;
      bit          flip;
      longint      x, y, z, dx, dy;
      longint      atans[24];
      atans = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
                32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
                32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
                32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
      flip = 0;
      t = ang - QUARTER_TURN;
      // fold into [-90,90) degrees
      if (t < 32'h8000_0000) begin
        ang  = ang - 32'h8000_0000;
        flip = 1;
      end
      z = longint'($signed(ang));
      x = R_GAIN;
      y = 0;
      for (int i = 0; i < 24; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atans[i];
        end else begin
          x += dx; y -= dy; z += atans[i];
        end
      end
      if (flip) begin
        x = -x; y = -y;
      end
      cs = (x > Q_ONE) ? Q_ONE : (x < -Q_ONE) ? -Q_ONE : x;
      sn = (y > Q_ONE) ? Q_ONE : (y < -Q_ONE) ? -Q_ONE : y;
    endfunction

    // haversine term a in Q30, same ordering as the distance
    function longint hav_term(longint qlat, longint qlon, longint plat, longint plon);
      longint c1, c2, s, unused, slat2, slon2, cc;
      sin_cos(32'(half_or_full(plat - qlat, 31)), unused, s);
      slat2 = (s * s) >>> 30;
      sin_cos(32'(half_or_full(plon - qlon, 31)), unused, s);
      slon2 = (s * s) >>> 30;
      sin_cos(32'(half_or_full(qlat, 32)), c1, unused);
      sin_cos(32'(half_or_full(plat, 32)), c2, unused);
      cc = (c1 * c2) >>> 30;
      return slat2 + ((cc * slon2) >>> 30);
    endfunction

    // note an accepted item and queue the reply it causes
    function void note_command(cmd_t cmd, logic [30:0] lat_bits, logic [31:0] lon_bits);
      table_reply_t r;
      longint       qlat, qlon, dl, dn, a, best;
      qlat = longint'($signed(lat_bits));
      qlon = longint'($signed(lon_bits));
      r.point_index = '0;
      if (cmd == CMD_FIND_ADD) begin
        r.status = ST_FULL;
        for (int i = 0; i < count; i++) begin
          dl = lat_tab[i] - qlat;
          dn = lon_tab[i] - qlon;
          if (dl < 0) dl = -dl;
          if (dn < 0) dn = -dn;
          if (dl < tolerance && dn < tolerance) begin
            r.point_index = 10'(i);
            r.status      = ST_MATCH;
            break;
          end
        end
        if (r.status == ST_FULL && count < DEPTH) begin
          r.point_index  = 10'(count);
          lat_tab[count] = int'(qlat);
          lon_tab[count] = int'(qlon);
          count++;
          r.status = ST_ADDED;
        end
      end else begin
        r.status = ST_EMPTY;
        best = 0;
        for (int i = 0; i < count; i++) begin
          a = hav_term(qlat, qlon, lat_tab[i], lon_tab[i]);
          if (r.status == ST_EMPTY || a < best) begin
            best          = a;
            r.point_index = 10'(i);
            r.status      = ST_MATCH;
          end
        end
      end
      r.point_count = 11'(count);
      replies.push_back(r);
    endfunction

    // compare one reply with the oldest expectation
    function void check_result(logic [OUT_BITS-1:0] data);
      table_reply_t e;
      if (replies.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: reply %h with nothing expected", data);
        return;
      end
      e = replies.pop_front();
      if (data[9:0] !== e.point_index || data[11:10] !== e.status ||
          data[22:12] !== e.point_count) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: index %0d status %0d count %0d, expected %0d %0d %0d",
                   data[9:0], data[11:10], data[22:12],
                   e.point_index, e.status, e.point_count);
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [TOL_W-1:0]        cfg_data;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [63:0]             in_tdata;
  logic [0:0]              in_tuser;
  logic                    out_tvalid;
  logic                    out_tready;
  logic [OUT_BITS-1:0]     out_tdata;

  point_table_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_req;
  int hold_left;
  int stall_cycles;

  geo_point_table_dedup_nearest_unit #(.TABLE_DEPTH(DEPTH)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Receiver: random stalls, or a long hold when asked
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Check each accepted reply
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_MAX) begin
        $display("** geo_point_table_dedup_nearest_unit: FAILED **");
        $finish;
      end
    end
  end

  // Offer one item and hold it until accepted, then maybe idle
  task automatic send_point(cmd_t cmd, logic [30:0] lat, logic [31:0] lon);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {1'b0, lon, lat};
    do @(posedge clk); while (!in_tready);
    sb.note_command(cmd, lat, lon);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (sb.replies.size() != 0) @(posedge clk);
  endtask

  // Write the tolerance once the unit is idle
  task automatic write_tolerance(int value);
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= TOL_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.tolerance = value;
  endtask

  // Build one random item; keep the table small so nearest scans stay short
  task automatic random_point(output cmd_t cmd, output logic [30:0] lat,
                              output logic [31:0] lon);
    int     j;
    longint t;
    bit     near_pick;
    cmd = ($urandom_range(0, 99) < 22) ? CMD_NEAREST : CMD_FIND_ADD;
    if (cmd == CMD_FIND_ADD && sb.tolerance == 0 && sb.count >= GROW_CAP) cmd = CMD_NEAREST;
    near_pick = (sb.count > 0) && (cmd == CMD_NEAREST ? $urandom_range(0, 1) == 1
                                                      : (sb.count >= SMALL_CAP ||
                                                         $urandom_range(0, 1) == 1));
    if (near_pick) begin
      j = $urandom_range(0, sb.count - 1);
      t = (sb.tolerance > 0) ? sb.tolerance - 1 : 0;
      lat = 31'(sb.lat_tab[j] + longint'($urandom_range(0, 2 * t)) - t);
      lon = 32'(sb.lon_tab[j] + longint'($urandom_range(0, 2 * t)) - t);
    end else begin
      lat = 31'($urandom);
      lon = $urandom;
    end
  endtask

  task automatic random_phase(int items);
    cmd_t        cmd;
    logic [30:0] lat;
    logic [31:0] lon;
    for (int n = 0; n < items; n++) begin
      random_point(cmd, lat, lon);
      send_point(cmd, lat, lon);
    end
  endtask

  initial begin
    sb = new();
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    hold_req   = 0;
    hold_left  = 0;
    stall_cycles  = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, tolerance edge, coordinate extremes, ties
    send_point(CMD_NEAREST, 31'd0, 32'd0);
    send_point(CMD_FIND_ADD, 31'd0, 32'd0);
    send_point(CMD_FIND_ADD, 31'sd999, -32'sd999);
    send_point(CMD_FIND_ADD, 31'sd1000, 32'd0);
    send_point(CMD_FIND_ADD, 31'h3FFF_FFFF, 32'h7FFF_FFFF);
    send_point(CMD_FIND_ADD, 31'h4000_0000, 32'h8000_0000);
    send_point(CMD_FIND_ADD, 31'sd900000000, 32'sd1800000000);
    send_point(CMD_FIND_ADD, -31'sd900000000, -32'sd1800000000);
    send_point(CMD_FIND_ADD, 31'h3FFF_FFFF, 32'h7FFF_FFFF);
    send_point(CMD_NEAREST, 31'd0, 32'd0);
    send_point(CMD_NEAREST, 31'sd500, 32'd0);
    send_point(CMD_NEAREST, 31'h4000_0000, 32'h8000_0000);
    send_point(CMD_NEAREST, 31'h3FFF_FFFF, 32'h7FFF_FFFF);
    send_point(CMD_NEAREST, 31'sd899999999, -32'sd1799999999);
    send_point(CMD_NEAREST, -31'sd450000000, 32'sd900000000);

    // Random: sender idles more rarely than the receiver, wide tolerance
    send_idle_pct = 15;
    recv_idle_pct = 72;
    write_tolerance(100000);
    random_phase(90);
    write_tolerance((1 << TOL_W) - 1);
    random_phase(85);

    // Swap the idling sides; tolerance zero, so nothing matches, then the reset tolerance
    send_idle_pct = 72;
    recv_idle_pct = 15;
    write_tolerance(0);
    random_phase(80);
    write_tolerance(int'(TOL_RESET));
    random_phase(90);

    // No idling; hold the receiver off while items keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 3000;
    random_phase(40);
    in_tvalid <= 1'b0;
    wait_drained();
    random_phase(140);

    // Fill the table to the end, then probe it full
    write_tolerance(0);
    while (sb.count < DEPTH) send_point(CMD_FIND_ADD, 31'($urandom), $urandom);
    send_point(CMD_FIND_ADD, 31'($urandom), $urandom);
    send_point(CMD_FIND_ADD, 31'd0, 32'd0);
    send_point(CMD_NEAREST, 31'($urandom), $urandom);
    in_tvalid <= 1'b0;

    wait_drained();
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.replies.size() == 0) begin
      $display("** geo_point_table_dedup_nearest_unit: PASSED **");
    end else begin
      $display("** geo_point_table_dedup_nearest_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/gptdn_pkg.sv
rtl/gptdn_ram.sv
rtl/gptdn_dp.sv
rtl/gptdn_ctrl.sv
rtl/geo_point_table_dedup_nearest_unit.sv
rtl/gptdn_chk.sv
verif/geo_point_table_dedup_nearest_unit_test.sv
